FILE: rtl/core/av3_pkg.sv
`default_nettype none
package av3_pkg;

	// normalized magnitudes have their leading one at this bit
	localparam int NORM_BIT = 30;
	localparam int NORM_W = NORM_BIT + 1;
	localparam int CORDIC_ITERS = 32;
	localparam int CORDIC_W = 36;
	localparam int GAIN_SHIFT = 30;
	localparam logic [29:0] INV_GAIN = 30'h26DD3B6A;
	localparam logic [33:0] PI_Q32 = 34'h3243F6A89;
	localparam logic [33:0] HALF_PI_Q32 = PI_Q32 >> 1;

	localparam logic [31:0] ATAN_Q32 [CORDIC_ITERS] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748, 32'd134174063, 32'd67103403, 32'd33553749,
		32'd16777131, 32'd8388597, 32'd4194303, 32'd2097152,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072,
		32'd65536, 32'd32768, 32'd16384, 32'd8192,
		32'd4096, 32'd2048, 32'd1024, 32'd512,
		32'd256, 32'd128, 32'd64, 32'd32,
		32'd16, 32'd8, 32'd4, 32'd2
	};

	// floor shift applied to each product so that sums fit
	function automatic int prod_shift(input int cw);
		return (2 * cw > 62) ? (2 * cw - 62) : 0;
	endfunction

	// width of a shifted signed product
	function automatic int prod_w(input int cw);
		return 2 * cw - prod_shift(cw);
	endfunction

	// width of the normalizer datapath
	function automatic int norm_w(input int cw);
		return (prod_w(cw) + 2 > NORM_W) ? (prod_w(cw) + 2) : NORM_W;
	endfunction

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
		logic [NORM_W-1:0] w0;
		logic [NORM_W-1:0] w1;
		logic special;
		logic dneg;
	} cordic_t;

endpackage
`default_nettype wire

FILE: rtl/core/av3_if.sv
`default_nettype none
interface av3_in_if #(parameter int CW = 16) ();
	logic valid;
	logic ready;
	logic signed [CW-1:0] a_x;
	logic signed [CW-1:0] a_y;
	logic signed [CW-1:0] a_z;
	logic signed [CW-1:0] b_x;
	logic signed [CW-1:0] b_y;
	logic signed [CW-1:0] b_z;
	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface av3_out_if #(parameter int AW = 15) ();
	logic valid;
	logic ready;
	logic [AW-1:0] angle;
	modport source (output valid, angle, input ready);
	modport sink (input valid, angle, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/av3_products.sv
`default_nettype none
module av3_products #(
	parameter int CW = 16,
	parameter int NW = 34
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic in_valid,
	input logic signed [CW-1:0] a_x,
	input logic signed [CW-1:0] a_y,
	input logic signed [CW-1:0] a_z,
	input logic signed [CW-1:0] b_x,
	input logic signed [CW-1:0] b_y,
	input logic signed [CW-1:0] b_z,
	output logic out_valid,
	output logic [NW-1:0] ux,
	output logic [NW-1:0] uy,
	output logic [NW-1:0] uz,
	output logic [NW-1:0] ud,
	output logic dneg,
	output logic special
);
	import av3_pkg::*;

	localparam int PSH = prod_shift(CW);
	localparam int PW = prod_w(CW);
	localparam int DW = PW + 2;

	function automatic logic signed [PW-1:0] mulsh(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] q);
		logic signed [2*CW-1:0] f;
		f = (2*CW)'(p) * (2*CW)'(q);
		return PW'(f >>> PSH);
	endfunction

	function automatic logic [NW-1:0] absw(input logic signed [DW-1:0] v);
		logic [DW-1:0] m;
		m = v[DW-1] ? $unsigned(-v) : $unsigned(v);
		return NW'(m);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [CW-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [PW-1:0] p_s2 [9];
	logic signed [PW:0] cx_s3, cy_s3, cz_s3;
	logic signed [DW-1:0] d_s3;
	logic [NW-1:0] ux_s4, uy_s4, uz_s4, ud_s4;
	logic dneg_s4, special_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ax_s1 <= a_x;
			ay_s1 <= a_y;
			az_s1 <= a_z;
			bx_s1 <= b_x;
			by_s1 <= b_y;
			bz_s1 <= b_z;
			// cross terms, then dot terms
			p_s2[0] <= mulsh(ay_s1, bz_s1);
			p_s2[1] <= mulsh(az_s1, by_s1);
			p_s2[2] <= mulsh(az_s1, bx_s1);
			p_s2[3] <= mulsh(ax_s1, bz_s1);
			p_s2[4] <= mulsh(ax_s1, by_s1);
			p_s2[5] <= mulsh(ay_s1, bx_s1);
			p_s2[6] <= mulsh(ax_s1, bx_s1);
			p_s2[7] <= mulsh(ay_s1, by_s1);
			p_s2[8] <= mulsh(az_s1, bz_s1);
			cx_s3 <= (PW+1)'(p_s2[0]) - (PW+1)'(p_s2[1]);
			cy_s3 <= (PW+1)'(p_s2[2]) - (PW+1)'(p_s2[3]);
			cz_s3 <= (PW+1)'(p_s2[4]) - (PW+1)'(p_s2[5]);
			d_s3 <= DW'(p_s2[6]) + DW'(p_s2[7]) + DW'(p_s2[8]);
			ux_s4 <= absw(DW'(cx_s3));
			uy_s4 <= absw(DW'(cy_s3));
			uz_s4 <= absw(DW'(cz_s3));
			ud_s4 <= absw(d_s3);
			dneg_s4 <= d_s3[DW-1];
			special_s4 <= (cx_s3 == '0) && (cy_s3 == '0) && (cz_s3 == '0);
		end
	end

	assign out_valid = v_s4;
	assign ux = ux_s4;
	assign uy = uy_s4;
	assign uz = uz_s4;
	assign ud = ud_s4;
	assign dneg = dneg_s4;
	assign special = special_s4;

endmodule
`default_nettype wire

FILE: rtl/core/av3_norm.sv
`default_nettype none
module av3_norm #(
	parameter int NW = 34
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic in_valid,
	input logic [NW-1:0] ux,
	input logic [NW-1:0] uy,
	input logic [NW-1:0] uz,
	input logic [NW-1:0] ud,
	input logic dneg,
	input logic special,
	output logic out_valid,
	output av3_pkg::cordic_t out_data
);
	import av3_pkg::*;

	localparam int L = $clog2(NW);
	localparam int RSH = NW - 1 - NORM_BIT;

	typedef struct packed {
		logic [3:0][NW-1:0] u;
		logic special;
		logic dneg;
	} norm_t;

	norm_t nrm_s [L+1];
	logic vld_s [L+1];
	cordic_t out_q;
	logic out_valid_q;

	assign nrm_s[0] = '{u: {ud, uz, uy, ux}, special: special, dneg: dneg};
	assign vld_s[0] = in_valid;

	// left shift all four together until the leading one of their union is at the top
	for (genvar k = 0; k < L; k++) begin : g_shift
		localparam int SH = 1 << (L - 1 - k);
		logic [NW-1:0] all;
		norm_t nxt;
		always_comb begin
			all = nrm_s[k].u[0] | nrm_s[k].u[1] | nrm_s[k].u[2] | nrm_s[k].u[3];
			nxt = nrm_s[k];
			if (all[NW-1 -: SH] == '0) begin
				for (int j = 0; j < 4; j++) begin
					nxt.u[j] = nrm_s[k].u[j] << SH;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (advance) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				nrm_s[k+1] <= nxt;
			end
		end
	end

	logic [3:0][NW-1:0] t;
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			t[j] = nrm_s[L].u[j] >> RSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_s[L];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.x <= {{(CORDIC_W-NORM_W){1'b0}}, t[0][NORM_W-1:0]};
			out_q.y <= {{(CORDIC_W-NORM_W){1'b0}}, t[1][NORM_W-1:0]};
			out_q.z <= '0;
			out_q.w0 <= t[2][NORM_W-1:0];
			out_q.w1 <= t[3][NORM_W-1:0];
			out_q.special <= nrm_s[L].special;
			out_q.dneg <= nrm_s[L].dneg;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/av3_cordic_stage.sv
`default_nettype none
module av3_cordic_stage #(
	parameter int ITER = 0,
	parameter bit ACC_Z = 1'b0
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic in_valid,
	input av3_pkg::cordic_t in_data,
	output logic out_valid,
	output av3_pkg::cordic_t out_data
);
	import av3_pkg::*;

	logic signed [CORDIC_W-1:0] xs, ys, ang;
	cordic_t nxt, out_q;
	logic out_valid_q;

	// one vectoring rotation toward the x axis
	always_comb begin
		xs = in_data.x >>> ITER;
		ys = in_data.y >>> ITER;
		ang = $signed({{(CORDIC_W-32){1'b0}}, ATAN_Q32[ITER]});
		nxt = in_data;
		if (!in_data.y[CORDIC_W-1]) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			if (ACC_Z) begin
				nxt.z = in_data.z + ang;
			end
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			if (ACC_Z) begin
				nxt.z = in_data.z - ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/av3_gain.sv
`default_nettype none
module av3_gain #(
	parameter bit SECOND = 1'b0
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic in_valid,
	input av3_pkg::cordic_t in_data,
	output logic out_valid,
	output av3_pkg::cordic_t out_data
);
	import av3_pkg::*;

	localparam int PRW = CORDIC_W - 1 + GAIN_SHIFT;

	logic [CORDIC_W-2:0] xp;
	logic [PRW-1:0] prod;
	logic signed [CORDIC_W-1:0] r;
	cordic_t nxt, out_q;
	logic out_valid_q;

	always_comb begin
		xp = in_data.x[CORDIC_W-1] ? '0 : in_data.x[CORDIC_W-2:0];
		prod = PRW'(xp) * PRW'(INV_GAIN);
		r = {1'b0, prod[PRW-1:GAIN_SHIFT]};
		nxt = in_data;
		nxt.z = '0;
		if (SECOND) begin
			// start the arctangent from the dot product and the cross length
			nxt.x = {{(CORDIC_W-NORM_W){1'b0}}, in_data.w1};
			nxt.y = r;
		end else begin
			nxt.x = r;
			nxt.y = {{(CORDIC_W-NORM_W){1'b0}}, in_data.w0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/angle_between_3d_vectors.sv
`default_nettype none
// channel   dir   payload                          handshake
// pair      in    a_x a_y a_z b_x b_y b_z signed    valid/ready
// result    out   angle, unsigned q2.13 radians     valid/ready
//
// one item enters per cycle unless a stall at the output holds the chain; most of
// the pipeline depth is in the three 32-step cordic chains
// all pipeline registers share one enable: the chain moves when the output
// register is empty or being taken, so a stall at the output holds every item
// reset clears only the valid bits; payload registers are not reset
module angle_between_3d_vectors #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input logic clk,
	input logic arst_n,
	av3_in_if.sink pair,
	av3_out_if.source result
);
	import av3_pkg::*;

	localparam int NW = norm_w(COMPONENT_WIDTH);
	localparam int AW = ANGLE_FRAC_BITS + 2;
	localparam logic [34:0] RND_HALF = 35'(1) << (31 - ANGLE_FRAC_BITS);
	localparam logic [34:0] PI_ROUND = (35'(PI_Q32) + RND_HALF) >> (32 - ANGLE_FRAC_BITS);

	logic advance;
	logic out_valid_q;
	logic [AW-1:0] angle_q;

	// whole pipeline steps together
	assign advance = !out_valid_q || result.ready;
	assign pair.ready = advance;

	// exact cross and dot products, then their magnitudes
	logic p_valid;
	logic [NW-1:0] ux, uy, uz, ud;
	logic dneg, special;

	av3_products #(.CW(COMPONENT_WIDTH), .NW(NW)) u_products (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.in_valid(pair.valid),
		.a_x(pair.a_x), .a_y(pair.a_y), .a_z(pair.a_z),
		.b_x(pair.b_x), .b_y(pair.b_y), .b_z(pair.b_z),
		.out_valid(p_valid),
		.ux(ux), .uy(uy), .uz(uz), .ud(ud),
		.dneg(dneg), .special(special)
	);

	// common shift so the largest magnitude has its top bit at bit 30
	cordic_t m1_s [CORDIC_ITERS+1];
	logic m1_v [CORDIC_ITERS+1];
	cordic_t m2_s [CORDIC_ITERS+1];
	logic m2_v [CORDIC_ITERS+1];
	cordic_t at_s [CORDIC_ITERS+1];
	logic at_v [CORDIC_ITERS+1];

	av3_norm #(.NW(NW)) u_norm (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.in_valid(p_valid),
		.ux(ux), .uy(uy), .uz(uz), .ud(ud),
		.dneg(dneg), .special(special),
		.out_valid(m1_v[0]), .out_data(m1_s[0])
	);

	// length of (cx, cy)
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_mag1
		av3_cordic_stage #(.ITER(i), .ACC_Z(1'b0)) u_stage (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.in_valid(m1_v[i]), .in_data(m1_s[i]),
			.out_valid(m1_v[i+1]), .out_data(m1_s[i+1])
		);
	end

	av3_gain #(.SECOND(1'b0)) u_gain1 (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.in_valid(m1_v[CORDIC_ITERS]), .in_data(m1_s[CORDIC_ITERS]),
		.out_valid(m2_v[0]), .out_data(m2_s[0])
	);

	// length of (r1, cz)
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_mag2
		av3_cordic_stage #(.ITER(i), .ACC_Z(1'b0)) u_stage (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.in_valid(m2_v[i]), .in_data(m2_s[i]),
			.out_valid(m2_v[i+1]), .out_data(m2_s[i+1])
		);
	end

	av3_gain #(.SECOND(1'b1)) u_gain2 (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.in_valid(m2_v[CORDIC_ITERS]), .in_data(m2_s[CORDIC_ITERS]),
		.out_valid(at_v[0]), .out_data(at_s[0])
	);

	// arctangent of cross length over |dot|
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_atan
		av3_cordic_stage #(.ITER(i), .ACC_Z(1'b1)) u_stage (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.in_valid(at_v[i]), .in_data(at_s[i]),
			.out_valid(at_v[i+1]), .out_data(at_s[i+1])
		);
	end

	// clamp to [0, pi/2], fold for negative dot, handle zero cross product
	cordic_t fin;
	logic [33:0] zc, theta;
	logic [33:0] th_s;
	logic th_v;
	logic [34:0] rounded;

	assign fin = at_s[CORDIC_ITERS];

	always_comb begin
		if (fin.z[CORDIC_W-1]) begin
			zc = '0;
		end else if (fin.z > $signed({{(CORDIC_W-34){1'b0}}, HALF_PI_Q32})) begin
			zc = HALF_PI_Q32;
		end else begin
			zc = fin.z[33:0];
		end
		if (fin.special) begin
			theta = fin.dneg ? PI_Q32 : '0;
		end else begin
			theta = fin.dneg ? (PI_Q32 - zc) : zc;
		end
	end

	// round half up to the output fraction
	assign rounded = 35'(th_s) + RND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_v <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			th_v <= at_v[CORDIC_ITERS];
			out_valid_q <= th_v;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			th_s <= theta;
			angle_q <= rounded[32-ANGLE_FRAC_BITS +: AW];
		end
	end

	assign result.valid = out_valid_q;
	assign result.angle = angle_q;

`ifndef SYNTH
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (angle_q <= PI_ROUND[AW-1:0]))
		else $error("angle above pi");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !pair.ready)
		else $error("input taken while result stalled");

	a_norm_leading_one: assert property (@(posedge clk) disable iff (!arst_n)
		(m1_v[0] && !m1_s[0].special) |->
		(m1_s[0].x[NORM_BIT] || m1_s[0].y[NORM_BIT] ||
		m1_s[0].w0[NORM_BIT] || m1_s[0].w1[NORM_BIT]))
		else $error("normalizer missed leading one");
`endif

endmodule
`default_nettype wire

FILE: test/angle_checker.sv
`default_nettype none
module angle_checker (
	input logic clk,
	input logic arst_n,
	av3_in_if.sink pair,
	av3_out_if.sink result,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] INV_GAIN_Q30 = 64'h26DD3B6A;
	localparam logic [63:0] PI_Q32 = 64'h3243F6A89;

	logic [14:0] angle_q[$];

	function automatic longint asr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint cordic_mag(input longint x0, input longint y0);
		longint x, y, xs, ys;
		x = x0;
		y = y0;
		for (int i = 0; i < 32; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y >= 0) begin
				x += ys;
				y -= xs;
			end else begin
				x -= ys;
				y += xs;
			end
		end
		return x;
	endfunction

	function automatic longint gain_fix(input longint x);
		logic [63:0] ux;
		ux = (x < 0) ? 64'd0 : 64'(x);
		return longint'((ux * INV_GAIN_Q30) >> 30);
	endfunction

	function automatic longint cordic_atan(input longint x0, input longint y0);
		longint x, y, z, xs, ys;
		x = x0;
		y = y0;
		z = 0;
		for (int i = 0; i < 32; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += longint'(av3_pkg::ATAN_Q32[i]);
			end else begin
				x -= ys;
				y += xs;
				z -= longint'(av3_pkg::ATAN_Q32[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(PI_Q32 >> 1)) z = longint'(PI_Q32 >> 1);
		return z;
	endfunction

	function automatic logic [14:0] vector_angle(input longint ax, ay, az, bx, by, bz);
		longint cx, cy, cz, d, r;
		logic [63:0] ux, uy, uz, ud, all, theta;
		int msb;
		cx = ay * bz - az * by;
		cy = az * bx - ax * bz;
		cz = ax * by - ay * bx;
		d = ax * bx + ay * by + az * bz;
		ux = (cx < 0) ? -cx : cx;
		uy = (cy < 0) ? -cy : cy;
		uz = (cz < 0) ? -cz : cz;
		ud = (d < 0) ? -d : d;
		if ((ux | uy | uz) == 0) begin
			theta = (d < 0) ? PI_Q32 : 64'd0;
		end else begin
			all = ux | uy | uz | ud;
			msb = 0;
			while (msb < 63 && (all >> (msb + 1)) != 0) msb++;
			if (msb > 30) begin
				ux >>= msb - 30; uy >>= msb - 30; uz >>= msb - 30; ud >>= msb - 30;
			end else begin
				ux <<= 30 - msb; uy <<= 30 - msb; uz <<= 30 - msb; ud <<= 30 - msb;
			end
			r = gain_fix(cordic_mag(longint'(ux), longint'(uy)));
			r = gain_fix(cordic_mag(r, longint'(uz)));
			theta = 64'(cordic_atan(longint'(ud), r));
			if (d < 0) theta = PI_Q32 - theta;
		end
		theta = (theta + (64'd1 << 18)) >> 19;
		return theta[14:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = angle_q.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (pair.valid && pair.ready)
				angle_q.push_back(vector_angle(pair.a_x, pair.a_y, pair.a_z,
					pair.b_x, pair.b_y, pair.b_z));
			if (result.valid && result.ready) begin
				if (angle_q.size() == 0)
					report_mismatch($sformatf("unexpected angle %0d", result.angle));
				else if (angle_q[0] != result.angle) begin
					report_mismatch($sformatf("angle %0d, want %0d", result.angle, angle_q[0]));
					void'(angle_q.pop_front());
				end else
					void'(angle_q.pop_front());
			end
		end
	end
endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int send_idle_pct = 13, recv_idle_pct = 80;
	int idle_cycles = 0;
	bit done = 1'b0;

	av3_in_if #(.CW(16)) pair_if ();
	av3_out_if #(.AW(15)) result_if ();

	angle_between_3d_vectors u_dut (
		.clk(clk), .arst_n(arst_n), .pair(pair_if.sink), .result(result_if.source)
	);

	angle_checker u_chk (
		.clk(clk), .arst_n(arst_n), .pair(pair_if.sink), .result(result_if.sink),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver side: random back-pressure at the falling edge
	always @(negedge clk)
		result_if.ready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog: cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((pair_if.valid && pair_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// drive one item, gaps first, then hold until accepted
	task automatic send_pair(input logic [15:0] ax, ay, az, bx, by, bz);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_if.valid <= 1'b0;
			@(negedge clk);
		end
		pair_if.valid <= 1'b1;
		pair_if.a_x <= ax; pair_if.a_y <= ay; pair_if.a_z <= az;
		pair_if.b_x <= bx; pair_if.b_y <= by; pair_if.b_z <= bz;
		do @(posedge clk); while (!pair_if.ready);
		@(negedge clk);
	endtask

	// random component, biased toward extremes and small values
	function automatic logic [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pair();
		logic [15:0] v[6];
		int k;
		foreach (v[i]) v[i] = rand_comp();
		case ($urandom_range(7))
			0: begin
				// parallel or anti-parallel: b is a small multiple of a
				k = $signed($urandom_range(6)) - 3;
				for (int i = 0; i < 3; i++) begin
					v[i] = 16'($signed($urandom_range(20000)) - 10000);
					v[i+3] = 16'(k * $signed(v[i]));
				end
			end
			1: begin
				// orthogonal: a in the xy plane, b its quarter turn there plus a random z
				v[2] = 16'(0); v[5] = 16'($urandom);
				v[3] = -v[1]; v[4] = v[0];
			end
			default: ;
		endcase
		send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	initial begin
		pair_if.valid = 1'b0;
		{pair_if.a_x, pair_if.a_y, pair_if.a_z} = '0;
		{pair_if.b_x, pair_if.b_y, pair_if.b_z} = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero vector, parallel, anti-parallel, orthogonal, extremes
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 16'h7fff, 16'h8000, 5);
		send_pair(3, 4, 5, 6, 8, 10);
		send_pair(3, 4, 5, -6, -8, -10);
		send_pair(1, 0, 0, 0, 1, 0);
		send_pair(1, 0, 0, 0, 0, 16'h8000);
		send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_pair(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
		send_pair(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_pair(16'h7fff, 0, 0, 16'h7fff, 1, 0);
		send_pair(16'h7fff, 0, 0, 16'h8000, 1, 0);
		send_pair(1, 1, 0, 1, 0, 0);
		send_pair(16'hffff, 16'hffff, 16'hffff, 1, 1, 1);
		send_pair(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

		// three idling phases, about 1600 random items in all
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 80 : 0;
			recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 13 : 0;
			repeat (530) random_pair();
		end
		pair_if.valid <= 1'b0;
		done = 1'b1;
	end

	// end of run: drain, then settle past the pipeline latency
	initial begin
		wait (done);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
